// ===== design/json_token_lexer_macros.svh =====
// assertion macros shared by the lexer checker
// depends on nothing; included by jtl_checker.sv
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define JTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/jtl_pkg.sv =====
// types, codes and character helpers of the json token lexer
// no dependencies; used by jtl_core, json_token_lexer, jtl_checker
`default_nettype none

package jtl_pkg;

  localparam int unsigned JtlMaxResults = 3;
  localparam int unsigned JtlFifoDepth  = 4;

  // lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_WS    = 3'd1;
  localparam logic [2:0] MODE_LIT   = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_NINT  = 3'd4;
  localparam logic [2:0] MODE_NFRAC = 3'd5;
  localparam logic [2:0] MODE_NEXP  = 3'd6;
  localparam logic [2:0] MODE_NEXPD = 3'd7;

  typedef enum logic [3:0] {
    CLS_END     = 4'd0,
    CLS_SPACE   = 4'd1,
    CLS_LBRACE  = 4'd2,
    CLS_RBRACE  = 4'd3,
    CLS_LBRACK  = 4'd4,
    CLS_RBRACK  = 4'd5,
    CLS_COMMA   = 4'd6,
    CLS_COLON   = 4'd7,
    CLS_STRING  = 4'd8,
    CLS_NUMBER  = 4'd9,
    CLS_BOOL    = 4'd10,
    CLS_NULL    = 4'd11,
    CLS_DISCARD = 4'd12,
    CLS_PENDING = 4'd13
  } cls_e;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_E   = 8'h45;
  localparam logic [7:0] CHAR_LBRACK    = 8'h5B;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_RBRACK    = 8'h5D;
  localparam logic [7:0] CHAR_LOWER_E   = 8'h65;
  localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE    = 8'h7D;

  typedef struct packed {
    logic       is_close;
    logic [7:0] out_byte;
    cls_e       token_class;
    logic       token_start;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       esc;
    logic [2:0] cand;   // bit0 true, bit1 false, bit2 null
    logic [2:0] pos;
  } lex_state_t;

  function automatic result_t mk_res(logic close, logic [7:0] b, cls_e cls, logic start);
    result_t r;
    r.is_close    = close;
    r.out_byte    = b;
    r.token_class = cls;
    r.token_start = start;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] char_true(logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h74;
      3'd1:    r = 8'h72;
      3'd2:    r = 8'h75;
      3'd3:    r = 8'h65;
      default: r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] char_false(logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h66;
      3'd1:    r = 8'h61;
      3'd2:    r = 8'h6C;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h65;
      default: r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] char_null(logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h6E;
      3'd1:    r = 8'h75;
      3'd2:    r = 8'h6C;
      3'd3:    r = 8'h6C;
      default: r = CHAR_NUL;
    endcase
    return r;
  endfunction

  // narrow the literal candidates by one alphabetic byte (never nul)
  function automatic lex_state_t lit_step(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r = s;
    if (char_true(s.pos) != c)  r.cand[0] = 1'b0;
    if (char_false(s.pos) != c) r.cand[1] = 1'b0;
    if (char_null(s.pos) != c)  r.cand[2] = 1'b0;
    if (s.pos != 3'd7) r.pos = s.pos + 3'd1;
    return r;
  endfunction

  function automatic cls_e lit_class(lex_state_t s, logic ign_ws);
    cls_e r;
    if (s.cand[0] && s.pos == 3'd4)      r = CLS_BOOL;
    else if (s.cand[1] && s.pos == 3'd5) r = CLS_BOOL;
    else if (s.cand[2] && s.pos == 3'd4) r = CLS_NULL;
    else if (ign_ws)                     r = CLS_DISCARD;
    else                                 r = CLS_SPACE;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/json_token_lexer.sv =====
// top level of the json token lexer: input register, lexing step, result queue
// depends on jtl_pkg and jtl_core
// One ASCII byte is taken per transfer on the slave stream and registered; the
// registered byte is lexed against the current state, and its zero to three results
// enter a small result queue that drives the master stream. Bytes that give at most
// one result flow at one per cycle while the queue has room. A byte that gives two or
// three results (punctuation, or a close followed by a fresh token) puts that many
// results in the queue, and the input stalls while the queue of FifoDepth entries has
// fewer than three free places. The user must write the ignore_whitespace register
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce this.
`default_nettype none

module json_token_lexer import jtl_pkg::*; #(
  parameter int unsigned FifoDepth = JtlFifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // ignore_whitespace
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [5:0] m_axis_tuser_o,   // [0] is_close, [4:1] token_class, [5] token_start
  output logic       m_axis_tlast_o    // last_result
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic             ign_ws_q;
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  lex_state_t       state_q, state_d;
  result_t          res [JtlMaxResults];
  logic [1:0]       res_cnt;
  result_t          fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             s1_fire, in_fire, pop;
  logic [1:0]       push_n;
  result_t          head;

  jtl_core u_core (
    .state_i  (state_q),
    .byte_i   (s1_byte_q),
    .ign_ws_i (ign_ws_q),
    .state_o  (state_d),
    .res_o    (res),
    .count_o  (res_cnt)
  );

  function automatic logic [PtrW-1:0] ptr_add(logic [PtrW-1:0] p, logic [1:0] k);
    logic [PtrW+1:0] s;
    s = {2'b00, p} + {{PtrW{1'b0}}, k};
    if (s >= (PtrW+2)'(FifoDepth)) s = s - (PtrW+2)'(FifoDepth);
    return s[PtrW-1:0];
  endfunction

  // room for the worst-case three results of the registered byte
  assign s1_fire         = s1_valid_q &&
                           (count_q <= CntW'(FifoDepth - JtlMaxResults));
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign push_n          = s1_fire ? res_cnt : 2'd0;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  assign wr_d    = ptr_add(wr_q, push_n);
  assign rd_d    = pop ? ptr_add(rd_q, 2'd1) : rd_q;
  assign count_d = count_q + CntW'(push_n) - CntW'(pop);

  assign head            = fifo_q[rd_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = head.out_byte;
  assign m_axis_tuser_o  = {head.token_start, head.token_class, head.is_close};
  assign m_axis_tlast_o  = head.last_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_ws_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      state_q    <= '{mode: MODE_IDLE, esc: 1'b0, cand: 3'b111, pos: 3'd0};
      wr_q       <= '0;
      rd_q       <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) ign_ws_q <= cfg_wdata_i;
      if (s_axis_tready_o) s1_valid_q <= s_axis_tvalid_i;
      if (s1_fire) state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_byte_q <= s_axis_tdata_i;
    for (int k = 0; k < JtlMaxResults; k++) begin
      if (2'(k) < push_n) fifo_q[ptr_add(wr_q, 2'(k))] <= res[k];
    end
  end

endmodule

`default_nettype wire

// ===== design/jtl_core.sv =====
// one-byte lexing step: results and next lexer state from current state
// depends on jtl_pkg
`default_nettype none

module jtl_core import jtl_pkg::*; (
  input  lex_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       ign_ws_i,
  output lex_state_t state_o,
  output result_t    res_o [JtlMaxResults],
  output logic [1:0] count_o
);

  always_comb begin
    lex_state_t ns;
    logic       fresh;
    logic [1:0] n;
    logic [7:0] c;
    cls_e       punct;
    logic       is_punct;

    c     = byte_i;
    ns    = state_i;
    fresh = 1'b1;
    n     = 2'd0;
    for (int k = 0; k < JtlMaxResults; k++) begin
      res_o[k] = mk_res(1'b0, CHAR_NUL, CLS_END, 1'b0);
    end

    case (state_i.mode)
      MODE_STR: begin
        fresh = 1'b0;
        if (c == CHAR_NUL) begin
          res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_STRING, 1'b0); n = n + 2'd1;
          ns.mode = MODE_IDLE;
          ns.esc  = 1'b0;
          res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_END, 1'b0); n = n + 2'd1;
        end else begin
          res_o[n] = mk_res(1'b0, c, CLS_STRING, 1'b0); n = n + 2'd1;
          if (state_i.esc) begin
            ns.esc = 1'b0;
          end else if (c == CHAR_BACKSLASH) begin
            ns.esc = 1'b1;
          end else if (c == CHAR_QUOTE) begin
            res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_STRING, 1'b0); n = n + 2'd1;
            ns.mode = MODE_IDLE;
          end
        end
      end
      MODE_WS: begin
        if (is_ws(c)) begin
          res_o[n] = mk_res(1'b0, c, CLS_SPACE, 1'b0); n = n + 2'd1;
          fresh = 1'b0;
        end else begin
          res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_SPACE, 1'b0); n = n + 2'd1;
          ns.mode = MODE_IDLE;
        end
      end
      MODE_LIT: begin
        if (is_alpha(c)) begin
          ns = lit_step(state_i, c);
          res_o[n] = mk_res(1'b0, c, CLS_PENDING, 1'b0); n = n + 2'd1;
          fresh = 1'b0;
        end else begin
          res_o[n] = mk_res(1'b1, CHAR_NUL, lit_class(state_i, ign_ws_i), 1'b0);
          n = n + 2'd1;
          ns.mode = MODE_IDLE;
        end
      end
      MODE_NINT, MODE_NFRAC, MODE_NEXP, MODE_NEXPD: begin
        fresh = 1'b0;
        case (state_i.mode)
          MODE_NINT: begin
            if (is_digit(c)) ns.mode = MODE_NINT;
            else if (c == CHAR_DOT) ns.mode = MODE_NFRAC;
            else if (c == CHAR_LOWER_E || c == CHAR_UPPER_E) ns.mode = MODE_NEXP;
            else fresh = 1'b1;
          end
          MODE_NFRAC: begin
            if (is_digit(c)) ns.mode = MODE_NFRAC;
            else if (c == CHAR_LOWER_E || c == CHAR_UPPER_E) ns.mode = MODE_NEXP;
            else fresh = 1'b1;
          end
          MODE_NEXP: begin
            if (c == CHAR_PLUS || c == CHAR_MINUS || is_digit(c)) ns.mode = MODE_NEXPD;
            else fresh = 1'b1;
          end
          default: begin
            if (!is_digit(c)) fresh = 1'b1;
          end
        endcase
        if (fresh) begin
          res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_NUMBER, 1'b0); n = n + 2'd1;
          ns.mode = MODE_IDLE;
        end else begin
          res_o[n] = mk_res(1'b0, c, CLS_NUMBER, 1'b0); n = n + 2'd1;
        end
      end
      default: begin
        ns.mode = MODE_IDLE;
      end
    endcase

    // byte that opens a token, or the one that closed the previous token
    is_punct = 1'b1;
    case (c)
      CHAR_LBRACE: punct = CLS_LBRACE;
      CHAR_RBRACE: punct = CLS_RBRACE;
      CHAR_LBRACK: punct = CLS_LBRACK;
      CHAR_RBRACK: punct = CLS_RBRACK;
      CHAR_COMMA:  punct = CLS_COMMA;
      CHAR_COLON:  punct = CLS_COLON;
      default: begin
        punct    = CLS_END;
        is_punct = 1'b0;
      end
    endcase

    if (fresh) begin
      ns.mode = MODE_IDLE;
      if (c == CHAR_NUL) begin
        res_o[n] = mk_res(1'b1, CHAR_NUL, CLS_END, 1'b0); n = n + 2'd1;
      end else if (is_ws(c)) begin
        if (!ign_ws_i) begin
          res_o[n] = mk_res(1'b0, c, CLS_SPACE, 1'b1); n = n + 2'd1;
          ns.mode = MODE_WS;
        end
      end else if (is_punct) begin
        res_o[n] = mk_res(1'b0, c, punct, 1'b1); n = n + 2'd1;
        res_o[n] = mk_res(1'b1, CHAR_NUL, punct, 1'b0); n = n + 2'd1;
      end else if (c == CHAR_QUOTE) begin
        res_o[n] = mk_res(1'b0, c, CLS_STRING, 1'b1); n = n + 2'd1;
        ns.esc  = 1'b0;
        ns.mode = MODE_STR;
      end else if (c == CHAR_MINUS || is_digit(c)) begin
        res_o[n] = mk_res(1'b0, c, CLS_NUMBER, 1'b1); n = n + 2'd1;
        ns.mode = MODE_NINT;
      end else if (is_alpha(c)) begin
        ns.cand = 3'b111;
        ns.pos  = 3'd0;
        ns      = lit_step(ns, c);
        res_o[n] = mk_res(1'b0, c, CLS_PENDING, 1'b1); n = n + 2'd1;
        ns.mode = MODE_LIT;
      end
    end

    if (n != 2'd0) res_o[n - 2'd1].last_result = 1'b1;

    state_o = ns;
    count_o = n;
  end

endmodule

`default_nettype wire

// ===== design/jtl_checker.sv =====
// port-level checks of the json token lexer, bound to the top level
// depends on jtl_pkg and json_token_lexer_macros.svh
`default_nettype none
`include "json_token_lexer_macros.svh"

module jtl_checker import jtl_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       m_axis_tvalid_o,
  input wire       m_axis_tready_i,
  input wire [7:0] m_axis_tdata_o,
  input wire [5:0] m_axis_tuser_o,
  input wire       m_axis_tlast_o
);

  logic out_xfer, out_close, out_punct;
  cls_e out_cls;

  assign out_xfer  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_close = m_axis_tuser_o[0];
  assign out_cls   = cls_e'(m_axis_tuser_o[4:1]);
  assign out_punct = out_cls inside {CLS_LBRACE, CLS_RBRACE, CLS_LBRACK, CLS_RBRACK,
                                     CLS_COMMA, CLS_COLON};

  `JTL_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o, "result valid dropped while stalled")

  // the rest of one byte's results are already queued
  `JTL_ASSERT_NEXT(a_burst_cont, clk_i, rst_ni, out_xfer && !m_axis_tlast_o,
    m_axis_tvalid_o, "gap inside the results of one byte")

  // punctuation byte is directly followed by its own close
  `JTL_ASSERT_NEXT(a_punct_close, clk_i, rst_ni, out_xfer && !out_close && out_punct,
    m_axis_tvalid_o && out_close && (out_cls == $past(out_cls)),
    "punctuation not closed by the next result")

  `JTL_ASSERT_NOW(a_end_last, clk_i, rst_ni, m_axis_tvalid_o && out_close && (out_cls == CLS_END),
    m_axis_tlast_o && (m_axis_tdata_o == CHAR_NUL) && !m_axis_tuser_o[5],
    "end close malformed")

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
